@@ rtl/mlsq_pkg.sv @@
// Shared types and constants of the multi-list stack and queue engine.
package mlsq_pkg;

  localparam int ListCount = 16;
  localparam int NodeCount = 256;
  localparam int ValueBits = 32;

  localparam int ListIdxW = $clog2(ListCount);
  localparam int NodeIdxW = $clog2(NodeCount);
  localparam int FreshW   = NodeIdxW + 1;

  typedef enum logic [1:0] {
    OpCreate = 2'd0,
    OpPush   = 2'd1,
    OpPop    = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StExists  = 3'd1,
    StMissing = 3'd2,
    StEmpty   = 3'd3,
    StFull    = 3'd4
  } status_e;

  typedef struct packed {
    op_e                opcode;
    logic [3:0]         list_id;
    logic               kind;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] popped_value;
    logic               pop_valid;
  } res_t;

  typedef logic [ListIdxW-1:0] list_idx_t;
  typedef logic [NodeIdxW-1:0] node_idx_t;

endpackage

@@ rtl/mlsq_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module mlsq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/multi_list_stack_queue_engine.sv @@
// Top level of the multi-list stack and queue engine with its node memories.
//
// The engine keeps ListCount lists of signed values that share a pool of
// NodeCount linked nodes; each list is created as a stack or a queue, and
// push and pop commands then add and remove values. A command word is taken
// when start_i is high while busy_o is low, and every command returns exactly
// one result word, shown on result_o for one cycle while result_valid_o is
// high. The receiver cannot stall, so results are never held back. In the
// cycle a command is taken the node memories are read at the head of the
// named list or at the head of the free list, and in the next cycle (busy_o
// high) the read data is combined with the list table, the memories are
// written back and the result is registered. No new command is taken while
// busy_o is high, so a command is taken only after the previous one has
// executed. The result word is shown in the cycle after the command's
// execute cycle. Nodes are handed out first from a region never used
// before and afterwards from a free list of recycled nodes, so no
// clearing pass is needed after reset.
module multi_list_stack_queue_engine
  import mlsq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  cmd_t cmd_i,
  output logic busy_o,
  output logic result_valid_o,
  output res_t result_o
);

  typedef enum logic {
    StIdle,
    StExec
  } state_e;

  state_e state_q, state_d;

  // Per-list table in flip-flops; only one list is looked at per cycle.
  logic      exists_q   [ListCount];
  logic      exists_d   [ListCount];
  logic      queue_q    [ListCount];
  logic      queue_d    [ListCount];
  logic      nonempty_q [ListCount];
  logic      nonempty_d [ListCount];
  node_idx_t head_q     [ListCount];
  node_idx_t head_d     [ListCount];
  node_idx_t tail_q     [ListCount];
  node_idx_t tail_d     [ListCount];

  // Node allocator state.
  logic [FreshW-1:0] fresh_q, fresh_d;
  node_idx_t         free_head_q, free_head_d;
  node_idx_t         free_tail_q, free_tail_d;
  logic              free_nonempty_q, free_nonempty_d;

  cmd_t cmd_q;
  logic result_valid_d;
  res_t result_d;
  res_t result_q;

  logic                 accept;
  list_idx_t            rd_lst;
  list_idx_t            lst;
  logic                 in_range;
  node_idx_t            link_raddr;
  node_idx_t            link_rdata;
  logic [ValueBits-1:0] value_rdata;
  logic                 value_we;
  node_idx_t            value_waddr;
  logic [ValueBits-1:0] value_wdata;
  logic                 link_we;
  node_idx_t            link_waddr;
  node_idx_t            link_wdata;
  logic                 take;
  node_idx_t            new_node;

  assign busy_o = (state_q == StExec);
  assign accept = start_i && !busy_o;

  // The read addresses come straight from the incoming word so that the
  // data is ready in the execute cycle.
  assign rd_lst     = list_idx_t'(cmd_i.list_id);
  assign link_raddr = (cmd_i.opcode == OpPop) ? head_q[rd_lst] : free_head_q;

  mlsq_ram #(
    .Width(ValueBits),
    .Depth(NodeCount)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (value_we),
    .waddr_i(value_waddr),
    .wdata_i(value_wdata),
    .re_i   (accept),
    .raddr_i(head_q[rd_lst]),
    .rdata_o(value_rdata)
  );

  mlsq_ram #(
    .Width(NodeIdxW),
    .Depth(NodeCount)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .re_i   (accept),
    .raddr_i(link_raddr),
    .rdata_o(link_rdata)
  );

  assign lst      = list_idx_t'(cmd_q.list_id);
  assign in_range = (32'(cmd_q.list_id) < ListCount);

  always_comb begin
    state_d         = state_q;
    exists_d        = exists_q;
    queue_d         = queue_q;
    nonempty_d      = nonempty_q;
    head_d          = head_q;
    tail_d          = tail_q;
    fresh_d         = fresh_q;
    free_head_d     = free_head_q;
    free_tail_d     = free_tail_q;
    free_nonempty_d = free_nonempty_q;

    result_d.status       = StOk;
    result_d.popped_value = '0;
    result_d.pop_valid    = 1'b0;
    result_valid_d        = 1'b0;

    value_we    = 1'b0;
    value_waddr = '0;
    value_wdata = ValueBits'(cmd_q.value);
    link_we     = 1'b0;
    link_waddr  = '0;
    link_wdata  = '0;
    take        = 1'b0;
    new_node    = '0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d        = StIdle;
        result_valid_d = 1'b1;
        case (cmd_q.opcode)
          OpCreate: begin
            if (!in_range) begin
              result_d.status = StMissing;
            end else if (exists_q[lst]) begin
              result_d.status = StExists;
            end else begin
              exists_d[lst]   = 1'b1;
              queue_d[lst]    = cmd_q.kind;
              nonempty_d[lst] = 1'b0;
            end
          end
          OpPush: begin
            if (!in_range || !exists_q[lst]) begin
              result_d.status = StMissing;
            end else if (fresh_q < FreshW'(NodeCount)) begin
              take     = 1'b1;
              new_node = fresh_q[NodeIdxW-1:0];
              fresh_d  = fresh_q + FreshW'(1);
            end else if (free_nonempty_q) begin
              take     = 1'b1;
              new_node = free_head_q;
              if (free_head_q == free_tail_q) begin
                free_nonempty_d = 1'b0;
              end else begin
                free_head_d = link_rdata;
              end
            end else begin
              result_d.status = StFull;
            end
            if (take) begin
              value_we    = 1'b1;
              value_waddr = new_node;
              if (!nonempty_q[lst]) begin
                head_d[lst]     = new_node;
                tail_d[lst]     = new_node;
                nonempty_d[lst] = 1'b1;
              end else if (queue_q[lst]) begin
                link_we     = 1'b1;
                link_waddr  = tail_q[lst];
                link_wdata  = new_node;
                tail_d[lst] = new_node;
              end else begin
                link_we     = 1'b1;
                link_waddr  = new_node;
                link_wdata  = head_q[lst];
                head_d[lst] = new_node;
              end
            end
          end
          OpPop: begin
            if (!in_range || !exists_q[lst]) begin
              result_d.status = StMissing;
            end else if (!nonempty_q[lst]) begin
              result_d.status = StEmpty;
            end else begin
              result_d.popped_value = 32'(signed'(value_rdata));
              result_d.pop_valid    = 1'b1;
              if (head_q[lst] == tail_q[lst]) begin
                nonempty_d[lst] = 1'b0;
              end else begin
                head_d[lst] = link_rdata;
              end
              // The freed node goes to the head of the free list.
              if (free_nonempty_q) begin
                link_we    = 1'b1;
                link_waddr = head_q[lst];
                link_wdata = free_head_q;
              end else begin
                free_tail_d     = head_q[lst];
                free_nonempty_d = 1'b1;
              end
              free_head_d = head_q[lst];
            end
          end
          default: begin
            result_d.status = StOk;
          end
        endcase
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      result_valid_o  <= 1'b0;
      result_q        <= '0;
      fresh_q         <= '0;
      free_head_q     <= '0;
      free_tail_q     <= '0;
      free_nonempty_q <= 1'b0;
      for (int i = 0; i < ListCount; i++) begin
        exists_q[i]   <= 1'b0;
        queue_q[i]    <= 1'b0;
        nonempty_q[i] <= 1'b0;
      end
    end else begin
      state_q         <= state_d;
      result_valid_o  <= result_valid_d;
      result_q        <= result_d;
      fresh_q         <= fresh_d;
      free_head_q     <= free_head_d;
      free_tail_q     <= free_tail_d;
      free_nonempty_q <= free_nonempty_d;
      exists_q        <= exists_d;
      queue_q         <= queue_d;
      nonempty_q      <= nonempty_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
    if (accept) begin
      cmd_q <= cmd_i;
    end
  end

  assign result_o = result_q;

endmodule
